// ----- sv/sharp_pkg.sv -----
// Types, codes and arithmetic helpers for the 3x3 RGB sharpen filter.
// No dependencies; imported by sharpen_conv3x3_rgb.
package sharp_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_DW     = 13;
    localparam int HW         = 13;
    localparam int OROW_W     = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        t_pix pix;
        logic last;
    } t_res;

    // 5 * centre minus the four neighbours, clamped to 0..255.
    function automatic logic [PIX_W-1:0] sharpen_chan(
        input logic [PIX_W-1:0] ctr,
        input logic [PIX_W-1:0] up,
        input logic [PIX_W-1:0] dn,
        input logic [PIX_W-1:0] lf,
        input logic [PIX_W-1:0] rt
    );
        logic signed [11:0] s;
        logic [PIX_W-1:0]   r;
        s = $signed({2'b00, ctr, 2'b00}) + $signed({4'b0000, ctr})
            - $signed({4'b0000, up}) - $signed({4'b0000, dn})
            - $signed({4'b0000, lf}) - $signed({4'b0000, rt});
        if (s < 12'sd0) begin
            r = '0;
        end else if (s > 12'sd255) begin
            r = '1;
        end else begin
            r = s[PIX_W-1:0];
        end
        return r;
    endfunction

    function automatic t_pix sharpen_pix(
        input t_pix ctr,
        input t_pix up,
        input t_pix dn,
        input t_pix lf,
        input t_pix rt
    );
        t_pix p;
        p.red   = sharpen_chan(ctr.red, up.red, dn.red, lf.red, rt.red);
        p.green = sharpen_chan(ctr.green, up.green, dn.green, lf.green, rt.green);
        p.blue  = sharpen_chan(ctr.blue, up.blue, dn.blue, lf.blue, rt.blue);
        return p;
    endfunction

endpackage

// ----- sv/sharpen_conv3x3_rgb.sv -----
// 3x3 RGB sharpen filter: line stores, window, counters and output queue.
// Depends on sharp_pkg for pixel types, command codes and the kernel.
//
// Usage: pixels of a frame enter in raster order on the input channel with
// i_cmd at the pixel code. Each request is accepted when i_in_valid is high
// and o_in_stall is low. Outputs trail the input by one row plus one pixel;
// once the whole frame is in, drain requests (i_cmd at the drain code) flush
// the last width+1 outputs, and o_frame_end marks the final pixel of the
// frame. Pixels sent after the frame is complete, and drains sent before,
// are dropped without an output.
// Timing: a request that produces a result is read from the line stores
// into the read stage registers, then written to the output queue, which
// presents it on o_out_valid. Throughput is one request per clock while
// o_in_stall is low, set by one read-modify-write pass on each line store.
// Stall: results wait in a two-entry output queue; o_in_stall rises only
// when that queue could otherwise overflow, so a held i_out_stall stops the
// input at most two requests later and nothing is lost.
// Reset: width 640, height 480, counters and window cleared; the line
// stores are not cleared and need no initialisation pass. A write on the
// configuration port also restarts the frame.
module sharpen_conv3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [sharp_pkg::PIX_W-1:0]  i_in_red,
    input  logic [sharp_pkg::PIX_W-1:0]  i_in_green,
    input  logic [sharp_pkg::PIX_W-1:0]  i_in_blue,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sharp_pkg::PIX_W-1:0]  o_out_red,
    output logic [sharp_pkg::PIX_W-1:0]  o_out_green,
    output logic [sharp_pkg::PIX_W-1:0]  o_out_blue,
    output logic                         o_frame_end,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [sharp_pkg::CFG_DW-1:0] i_cfg_data
);
    import sharp_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam logic [WW-1:0] W_RST =
        WW'((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST);

    // Line stores: upper holds the row before middle.
    t_pix mem_upper  [MAX_WIDTH];
    t_pix mem_middle [MAX_WIDTH];

    logic [WW-1:0]     r_w;
    logic [HW-1:0]     r_h;
    logic [HW-1:0]     r_in_row;
    logic [AW-1:0]     r_in_col;
    logic [OROW_W-1:0] r_out_row;
    logic [AW-1:0]     r_out_col;

    t_pix r_win [3][3];

    // Read stage registers.
    t_pix    r_rd_upper;
    t_pix    r_rd_middle;
    logic    r_fwd;
    t_pix    r_fwd_upper;
    t_pix    r_fwd_middle;
    logic    r_s1_pix;
    logic    r_s1_res;
    logic    r_s1_border;
    logic    r_s1_sel_mid;
    logic    r_s1_last;
    logic [AW-1:0] r_s1_addr;
    t_pix    r_s1_px;

    // Output queue.
    t_res       r_q [2];
    logic       r_q_wp;
    logic       r_q_rp;
    logic [1:0] r_q_cnt;

    logic [WW-1:0] w_m1;
    logic [HW-1:0] h_m1;
    logic          acc;
    logic          pix_go;
    logic          drn_go;
    logic          pix_res;
    logic          adv_out;
    logic          out_col_end;
    logic          out_row_end;
    logic          frame_last;
    logic [AW-1:0] rd_addr;
    logic          pop;
    logic [2:0]    q_need;
    t_pix          s1_upper;
    t_pix          s1_middle;
    t_pix          s1_filt;
    t_res          s1_out;
    logic [WW-1:0] n_w;
    logic [HW-1:0] n_h;
    logic          cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    assign w_m1 = r_w - WW'(1);
    assign h_m1 = r_h - HW'(1);

    assign pop         = (r_q_cnt != 2'd0) && !i_out_stall;
    assign q_need      = {1'b0, r_q_cnt} - {2'b00, pop} + {2'b00, r_s1_res};
    assign o_in_stall  = (q_need >= 3'd2);
    assign acc         = i_in_valid && !o_in_stall;

    always_comb begin
        pix_go  = acc && (i_cmd == CMD_PIXEL) && (r_in_row < r_h);
        drn_go  = acc && (i_cmd == CMD_DRAIN) && (r_in_row >= r_h);
        pix_res = pix_go && ((r_in_row >= HW'(2)) ||
                             ((r_in_row == HW'(1)) && (r_in_col != '0)));
        adv_out     = pix_res || drn_go;
        out_col_end = (WW'(r_out_col) == w_m1);
        out_row_end = ({1'b0, r_out_row} == h_m1);
        frame_last  = out_row_end && out_col_end;
        rd_addr     = (i_cmd == CMD_DRAIN) ? r_out_col : r_in_col;
    end

    // Configuration values are clamped once, when written.
    always_comb begin
        if (i_cfg_data[10:0] < 11'd3) begin
            n_w = WW'(3);
        end else if (32'(i_cfg_data[10:0]) > MAX_WIDTH) begin
            n_w = WW'(MAX_WIDTH);
        end else begin
            n_w = WW'(i_cfg_data[10:0]);
        end
        if (i_cfg_data < CFG_DW'(3)) begin
            n_h = HW'(3);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            n_h = HW'(MAX_HEIGHT);
        end else begin
            n_h = HW'(i_cfg_data);
        end
    end

    // The last pixel of a frame writes the very entry that the first drain
    // reads, maybe while the write is under way, so that write is forwarded.
    always_comb begin
        s1_middle = r_fwd ? r_fwd_middle : r_rd_middle;
        s1_upper  = r_fwd ? r_fwd_upper  : r_rd_upper;
        s1_filt   = sharpen_pix(r_win[1][2], r_win[0][2], r_win[2][2],
                                r_win[1][1], s1_middle);
        if (!r_s1_pix) begin
            s1_out.pix = r_s1_sel_mid ? s1_middle : s1_upper;
        end else if (r_s1_border) begin
            s1_out.pix = r_win[1][2];
        end else begin
            s1_out.pix = s1_filt;
        end
        s1_out.last = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        r_rd_upper  <= mem_upper[rd_addr];
        r_rd_middle <= mem_middle[rd_addr];
        if (r_s1_pix) begin
            mem_upper[r_s1_addr]  <= s1_middle;
            mem_middle[r_s1_addr] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_upper  <= s1_middle;
        r_fwd_middle <= r_s1_px;
        r_s1_addr    <= rd_addr;
        r_s1_px      <= '{red: i_in_red, green: i_in_green, blue: i_in_blue};
        r_s1_border  <= (r_out_row == '0) || out_row_end ||
                        (r_out_col == '0) || out_col_end;
        r_s1_sel_mid <= out_row_end;
        r_s1_last    <= drn_go && frame_last;
        if (r_s1_res) begin
            r_q[r_q_wp] <= s1_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= W_RST;
            r_h       <= HW'(HEIGHT_RST);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_fwd     <= 1'b0;
            r_s1_pix  <= 1'b0;
            r_s1_res  <= 1'b0;
            r_q_wp    <= 1'b0;
            r_q_rp    <= 1'b0;
            r_q_cnt   <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_fwd    <= r_s1_pix && (r_s1_addr == rd_addr);
            r_s1_pix <= pix_go;
            r_s1_res <= adv_out;

            if (r_s1_pix) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= s1_upper;
                r_win[1][2] <= s1_middle;
                r_win[2][2] <= r_s1_px;
            end

            if (pix_go) begin
                if (WW'(r_in_col) == w_m1) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + HW'(1);
                end else begin
                    r_in_col <= r_in_col + AW'(1);
                end
            end

            if (adv_out) begin
                if (out_col_end) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + OROW_W'(1);
                end else begin
                    r_out_col <= r_out_col + AW'(1);
                end
            end

            if (drn_go && frame_last) begin
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end

            if (cfg_we) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_w <= n_w;
                    REG_HEIGHT: r_h <= n_h;
                    default:    r_w <= r_w;
                endcase
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end

            if (r_s1_res) begin
                r_q_wp <= ~r_q_wp;
            end
            if (pop) begin
                r_q_rp <= ~r_q_rp;
            end
            r_q_cnt <= r_q_cnt + {1'b0, r_s1_res} - {1'b0, pop};
        end
    end

    assign o_out_valid = (r_q_cnt != 2'd0);
    assign o_out_red   = r_q[r_q_rp].pix.red;
    assign o_out_green = r_q[r_q_rp].pix.green;
    assign o_out_blue  = r_q[r_q_rp].pix.blue;
    assign o_frame_end = r_q[r_q_rp].last;

endmodule
